// ===== hw/rtl/kqfu_pkg.sv =====
// Shared constants, types and helpers for the quick-find union unit.
`default_nettype none

package kqfu_pkg;

    // Label memory depth and derived widths
    localparam int MAX_NODES = 1024;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);

    typedef logic [NODE_W-1:0] t_node;
    typedef logic [CNT_W-1:0]  t_cnt;

    // Write port of the label memory
    typedef struct packed {
        logic  we;
        t_node addr;
        t_node data;
    } t_ram_wr;

    // Read port of the label memory
    typedef struct packed {
        logic  re;
        t_node addr;
    } t_ram_rd;

    // Node count in use: zero acts as one, anything above the depth as the depth
    function automatic t_cnt eff_count(input t_cnt value);
        t_cnt n;
        n = value;
        if (n == '0) begin
            n = CNT_W'(1);
        end else if (n > CNT_W'(MAX_NODES)) begin
            n = CNT_W'(MAX_NODES);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/kqfu_label_ram.sv =====
// Class label memory: one write port, one read port, registered read data.
`default_nettype none

module kqfu_label_ram (
    input  wire                    i_clk,
    input  kqfu_pkg::t_ram_wr      i_wr,
    input  kqfu_pkg::t_ram_rd      i_rd,
    output kqfu_pkg::t_node        o_rdata
);
    import kqfu_pkg::*;

    t_node mem [MAX_NODES];
    t_node r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd.re) begin
            r_rdata <= mem[i_rd.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/kruskal_quick_find_union_unit.sv =====
// Top level: Kruskal edge acceptance with quick-find labels kept in a memory.
// A restart or bad-id transaction gives its result in the cycle after start; an edge
// reads its two labels in ST_RD_A and ST_RD_B, then reports. An accepted edge then
// stays busy for a relabel sweep over node_count labels (one label read-modify-write
// per cycle, set by the single memory read port). Reset, a restart action and a
// node_count write run a clearing pass over all 1024 labels (busy high) that loads
// each label with its own index.
// The receiver cannot stall: o_valid marks each result for exactly one cycle.
`default_nettype none

module kruskal_quick_find_union_unit (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // Command channel
    input  wire                     start,
    output logic                    busy,
    input  wire                     i_action,
    input  wire  kqfu_pkg::t_node   i_first_node,
    input  wire  kqfu_pkg::t_node   i_second_node,
    // Configuration
    input  wire                     i_cfg_we,
    input  wire  kqfu_pkg::t_cnt    i_cfg_wdata,
    // Results
    output logic                    o_valid,
    output logic                    o_accepted,
    output kqfu_pkg::t_node         o_first_label,
    output kqfu_pkg::t_node         o_second_label,
    output kqfu_pkg::t_node         o_merged_label,
    output kqfu_pkg::t_cnt          o_components_left,
    output logic                    o_tree_done,
    output logic                    o_bad_node
);
    import kqfu_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RD_A  = 3'd2;
    localparam logic [2:0] ST_RD_B  = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;

    logic [2:0] r_state, n_state;
    t_cnt       r_idx, n_idx;
    t_cnt       r_node_count, n_node_count;
    t_cnt       r_comp, n_comp;
    logic       r_finished, n_finished;
    t_node      r_b, n_b;
    t_node      r_la, n_la;
    t_node      r_hi, n_hi;
    t_node      r_lo, n_lo;

    logic       r_valid, n_valid;
    logic       r_acc, n_acc;
    t_node      r_out_la, n_out_la;
    t_node      r_out_lb, n_out_lb;
    t_node      r_out_merged, n_out_merged;
    t_cnt       r_out_comp, n_out_comp;
    logic       r_out_done, n_out_done;
    logic       r_out_bad, n_out_bad;

    t_ram_wr    wr;
    t_ram_rd    rd;
    t_node      rdata;
    t_cnt       eff_n;
    t_cnt       cfg_n;
    t_cnt       dec_comp;
    logic       accept;

    kqfu_label_ram u_ram (
        .i_clk   (i_clk),
        .i_wr    (wr),
        .i_rd    (rd),
        .o_rdata (rdata)
    );

    assign eff_n    = eff_count(r_node_count);
    assign cfg_n    = eff_count(i_cfg_wdata);
    assign dec_comp = r_comp - CNT_W'(1);
    assign accept   = start && (r_state == ST_IDLE);
    assign busy     = (r_state != ST_IDLE);

    // Sequencer: lookups, relabel sweep and clearing pass
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_node_count = r_node_count;
        n_comp       = r_comp;
        n_finished   = r_finished;
        n_b          = r_b;
        n_la         = r_la;
        n_hi         = r_hi;
        n_lo         = r_lo;
        n_valid      = 1'b0;
        n_acc        = 1'b0;
        n_out_la     = '0;
        n_out_lb     = '0;
        n_out_merged = '0;
        n_out_comp   = r_comp;
        n_out_done   = r_finished;
        n_out_bad    = 1'b0;
        wr           = '0;
        rd           = '0;

        case (r_state)
            ST_CLEAR: begin
                wr.we   = 1'b1;
                wr.addr = r_idx[NODE_W-1:0];
                wr.data = r_idx[NODE_W-1:0];
                if (r_idx == CNT_W'(MAX_NODES - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_action) begin
                        // restart: reload counts, then clear the labels
                        n_comp     = eff_n;
                        n_finished = (eff_n <= CNT_W'(1));
                        n_valid    = 1'b1;
                        n_out_comp = eff_n;
                        n_out_done = (eff_n <= CNT_W'(1));
                        n_idx      = '0;
                        n_state    = ST_CLEAR;
                    end else if ({1'b0, i_first_node} >= eff_n ||
                                 {1'b0, i_second_node} >= eff_n) begin
                        n_valid   = 1'b1;
                        n_out_bad = 1'b1;
                    end else begin
                        rd.re   = 1'b1;
                        rd.addr = i_first_node;
                        n_b     = i_second_node;
                        n_state = ST_RD_A;
                    end
                end
            end
            ST_RD_A: begin
                n_la    = rdata;
                rd.re   = 1'b1;
                rd.addr = r_b;
                n_state = ST_RD_B;
            end
            ST_RD_B: begin
                n_valid  = 1'b1;
                n_out_la = r_la;
                n_out_lb = rdata;
                if (!r_finished && (r_la != rdata)) begin
                    n_hi         = (r_la > rdata) ? r_la : rdata;
                    n_lo         = (r_la > rdata) ? rdata : r_la;
                    n_acc        = 1'b1;
                    n_out_merged = (r_la > rdata) ? rdata : r_la;
                    n_comp       = dec_comp;
                    n_finished   = (dec_comp <= CNT_W'(1));
                    n_out_comp   = dec_comp;
                    n_out_done   = (dec_comp <= CNT_W'(1));
                    rd.re        = 1'b1;
                    rd.addr      = '0;
                    n_idx        = '0;
                    n_state      = ST_SCAN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                // data of entry r_idx is present; fetch the next one
                if (rdata == r_hi) begin
                    wr.we   = 1'b1;
                    wr.addr = r_idx[NODE_W-1:0];
                    wr.data = r_lo;
                end
                rd.re   = 1'b1;
                rd.addr = r_idx[NODE_W-1:0] + NODE_W'(1);
                if (r_idx == eff_n - CNT_W'(1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            default: begin
                n_idx   = '0;
                n_state = ST_CLEAR;
            end
        endcase

        // node_count write restarts the block
        if (i_cfg_we) begin
            n_node_count = i_cfg_wdata;
            n_comp       = cfg_n;
            n_finished   = (cfg_n <= CNT_W'(1));
            n_idx        = '0;
            n_state      = ST_CLEAR;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_idx        <= '0;
            r_node_count <= CNT_W'(MAX_NODES);
            r_comp       <= eff_count(CNT_W'(MAX_NODES));
            r_finished   <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_node_count <= n_node_count;
            r_comp       <= n_comp;
            r_finished   <= n_finished;
            r_valid      <= n_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_b          <= n_b;
        r_la         <= n_la;
        r_hi         <= n_hi;
        r_lo         <= n_lo;
        r_acc        <= n_acc;
        r_out_la     <= n_out_la;
        r_out_lb     <= n_out_lb;
        r_out_merged <= n_out_merged;
        r_out_comp   <= n_out_comp;
        r_out_done   <= n_out_done;
        r_out_bad    <= n_out_bad;
    end

    assign o_valid           = r_valid;
    assign o_accepted        = r_acc;
    assign o_first_label     = r_out_la;
    assign o_second_label    = r_out_lb;
    assign o_merged_label    = r_out_merged;
    assign o_components_left = r_out_comp;
    assign o_tree_done       = r_out_done;
    assign o_bad_node        = r_out_bad;

    // A restart transaction reports at once and enters the clearing pass
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_action) |=> (o_valid && r_state == ST_CLEAR))
        else $error("restart did not report and clear");

    // An accepted edge merges two distinct labels into the smaller one
    a_merge_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_accepted) |->
            (o_first_label != o_second_label &&
             o_merged_label <= o_first_label && o_merged_label <= o_second_label))
        else $error("merged label is not the smaller of two distinct labels");

    // A bad id never yields an accepted edge
    a_bad_rejects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_node) |-> !o_accepted)
        else $error("edge with bad id accepted");

    // Done flag agrees with the component count
    a_done_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_tree_done == (o_components_left <= CNT_W'(1))))
        else $error("tree_done disagrees with components_left");

    // No label write while idle
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && !i_cfg_we) |-> !wr.we)
        else $error("label memory written while idle");

endmodule

`default_nettype wire

// ===== tb/kqfu_merge_checker.sv =====
// Action codes and a scoreboard that predicts and checks the quick-find union unit.
`timescale 1ns / 100ps

package kqfu_tb_pkg;

    // Command action field
    typedef enum logic {
        ACT_EDGE    = 1'b0,
        ACT_RESTART = 1'b1
    } t_action;

endpackage

module kqfu_merge_checker (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // Command channel as seen at the block
    input  wire                     i_start,
    input  wire                     i_busy,
    input  wire                     i_action,
    input  wire  kqfu_pkg::t_node   i_first_node,
    input  wire  kqfu_pkg::t_node   i_second_node,
    // Configuration write
    input  wire                     i_cfg_we,
    input  wire  kqfu_pkg::t_cnt    i_cfg_wdata,
    // Result channel
    input  wire                     i_valid,
    input  wire                     i_accepted,
    input  wire  kqfu_pkg::t_node   i_first_label,
    input  wire  kqfu_pkg::t_node   i_second_label,
    input  wire  kqfu_pkg::t_node   i_merged_label,
    input  wire  kqfu_pkg::t_cnt    i_components_left,
    input  wire                     i_tree_done,
    input  wire                     i_bad_node,
    // Status for the test top
    output int                      o_fail_count,
    output int                      o_outstanding,
    output int                      o_settings,
    output int                      o_restarts,
    output int                      o_merges,
    output int                      o_bad_ids,
    output int                      o_done_results
);
    import kqfu_tb_pkg::*;

    typedef struct packed {
        logic            accepted;
        kqfu_pkg::t_node first_label;
        kqfu_pkg::t_node second_label;
        kqfu_pkg::t_node merged_label;
        kqfu_pkg::t_cnt  components_left;
        logic            tree_done;
        logic            bad_node;
    } t_union_outcome;

    // Shadow copy of the label memory and counters
    kqfu_pkg::t_node label_mem [kqfu_pkg::MAX_NODES];
    kqfu_pkg::t_cnt  node_limit;
    kqfu_pkg::t_cnt  comp_total;
    logic            tree_finished;
    t_union_outcome  outcome_q [$];

    initial begin
        o_fail_count   = 0;
        o_outstanding  = 0;
        o_settings     = 0;
        o_restarts     = 0;
        o_merges       = 0;
        o_bad_ids      = 0;
        o_done_results = 0;
    end

    // Nodes actually in use: zero acts as one, capped at the memory depth
    function automatic int live_nodes();
        int n;
        n = node_limit;
        if (n == 0) begin
            n = 1;
        end else if (n > kqfu_pkg::MAX_NODES) begin
            n = kqfu_pkg::MAX_NODES;
        end
        return n;
    endfunction

    function automatic void reload_labels();
        for (int i = 0; i < kqfu_pkg::MAX_NODES; i++) begin
            label_mem[i] = kqfu_pkg::t_node'(i);
        end
        comp_total    = kqfu_pkg::t_cnt'(live_nodes());
        tree_finished = (comp_total <= 1);
    endfunction

    // Apply one transaction to the shadow state and return its result
    function automatic t_union_outcome predict_union(input logic act,
                                                     input kqfu_pkg::t_node a,
                                                     input kqfu_pkg::t_node b);
        t_union_outcome  res;
        int              n;
        kqfu_pkg::t_node hi;
        kqfu_pkg::t_node lo;
        n   = live_nodes();
        res = '0;
        if (act == ACT_RESTART) begin
            reload_labels();
        end else if (a >= n || b >= n) begin
            res.bad_node = 1'b1;
        end else begin
            res.first_label  = label_mem[a];
            res.second_label = label_mem[b];
            if (!tree_finished && label_mem[a] != label_mem[b]) begin
                hi = (label_mem[a] > label_mem[b]) ? label_mem[a] : label_mem[b];
                lo = (label_mem[a] > label_mem[b]) ? label_mem[b] : label_mem[a];
                for (int j = 0; j < n; j++) begin
                    if (label_mem[j] == hi) begin
                        label_mem[j] = lo;
                    end
                end
                res.accepted     = 1'b1;
                res.merged_label = lo;
                if (comp_total != 0) begin
                    comp_total = comp_total - 1'b1;
                end
                if (comp_total <= 1) begin
                    tree_finished = 1'b1;
                end
            end
        end
        res.components_left = comp_total;
        res.tree_done       = tree_finished;
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [10:0] got,
                                 input logic [10:0] want);
        if (o_fail_count < 40) begin
            $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        end
        o_fail_count++;
    endtask

    // Results are checked before new transactions are queued: a result never
    // comes out in the cycle its transaction goes in
    always @(posedge i_clk) begin : track
        t_union_outcome want;
        if (!i_rst_n) begin
            node_limit = kqfu_pkg::t_cnt'(kqfu_pkg::MAX_NODES);
            reload_labels();
            outcome_q.delete();
        end else begin
            if (i_valid) begin
                if (outcome_q.size() == 0) begin
                    flag_mismatch("result with no transaction pending", 1, 0);
                end else begin
                    want = outcome_q.pop_front();
                    if (i_accepted !== want.accepted)
                        flag_mismatch("accepted", i_accepted, want.accepted);
                    if (i_first_label !== want.first_label)
                        flag_mismatch("first_label", i_first_label, want.first_label);
                    if (i_second_label !== want.second_label)
                        flag_mismatch("second_label", i_second_label, want.second_label);
                    if (i_merged_label !== want.merged_label)
                        flag_mismatch("merged_label", i_merged_label, want.merged_label);
                    if (i_components_left !== want.components_left)
                        flag_mismatch("components_left", i_components_left,
                                      want.components_left);
                    if (i_tree_done !== want.tree_done)
                        flag_mismatch("tree_done", i_tree_done, want.tree_done);
                    if (i_bad_node !== want.bad_node)
                        flag_mismatch("bad_node", i_bad_node, want.bad_node);
                    if (want.accepted) o_merges++;
                    if (want.bad_node) o_bad_ids++;
                    if (want.tree_done) o_done_results++;
                end
            end
            if (i_cfg_we) begin
                node_limit = i_cfg_wdata;
                reload_labels();
                o_settings++;
            end else if (i_start && !i_busy) begin
                if (i_action == ACT_RESTART) o_restarts++;
                outcome_q.push_back(predict_union(i_action, i_first_node, i_second_node));
            end
        end
        o_outstanding = outcome_q.size();
    end

endmodule

// ===== tb/kruskal_quick_find_union_unit_test.sv =====
// Test top: drives edges, restarts and node-count writes into the union unit.
`timescale 1ns / 100ps

module kruskal_quick_find_union_unit_test;
    import kqfu_tb_pkg::*;

    localparam int RANDOM_ITEMS = 580;
    localparam int IDLE_LIMIT   = 10000;
    localparam int DRAIN_CYCLES = 1100;

    logic            i_clk         = 1'b0;
    logic            i_rst_n       = 1'b0;
    logic            start         = 1'b0;
    logic            i_action      = ACT_EDGE;
    kqfu_pkg::t_node i_first_node  = '0;
    kqfu_pkg::t_node i_second_node = '0;
    logic            i_cfg_we      = 1'b0;
    kqfu_pkg::t_cnt  i_cfg_wdata   = '0;

    logic            busy;
    logic            o_valid;
    logic            o_accepted;
    kqfu_pkg::t_node o_first_label;
    kqfu_pkg::t_node o_second_label;
    kqfu_pkg::t_node o_merged_label;
    kqfu_pkg::t_cnt  o_components_left;
    logic            o_tree_done;
    logic            o_bad_node;

    int fail_count;
    int outstanding;
    int settings;
    int restarts;
    int merges;
    int bad_ids;
    int done_results;

    int items_sent  = 0;
    int burst_left  = 0;
    int idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    kruskal_quick_find_union_unit DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_action          (i_action),
        .i_first_node      (i_first_node),
        .i_second_node     (i_second_node),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_valid           (o_valid),
        .o_accepted        (o_accepted),
        .o_first_label     (o_first_label),
        .o_second_label    (o_second_label),
        .o_merged_label    (o_merged_label),
        .o_components_left (o_components_left),
        .o_tree_done       (o_tree_done),
        .o_bad_node        (o_bad_node)
    );

    kqfu_merge_checker scoreboard (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_action          (i_action),
        .i_first_node      (i_first_node),
        .i_second_node     (i_second_node),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_valid           (o_valid),
        .i_accepted        (o_accepted),
        .i_first_label     (o_first_label),
        .i_second_label    (o_second_label),
        .i_merged_label    (o_merged_label),
        .i_components_left (o_components_left),
        .i_tree_done       (o_tree_done),
        .i_bad_node        (o_bad_node),
        .o_fail_count      (fail_count),
        .o_outstanding     (outstanding),
        .o_settings        (settings),
        .o_restarts        (restarts),
        .o_merges          (merges),
        .o_bad_ids         (bad_ids),
        .o_done_results    (done_results)
    );

    // One command transaction; start stays high through a burst, drops for a gap
    task automatic offer(input logic act, input kqfu_pkg::t_node a,
                         input kqfu_pkg::t_node b);
        start         <= 1'b1;
        i_action      <= act;
        i_first_node  <= a;
        i_second_node <= b;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 5);
        end
    endtask

    // Node-count write once the unit is idle and every result is back
    task automatic write_node_count(input kqfu_pkg::t_cnt value);
        if (start) start <= 1'b0;
        while (busy || outstanding != 0) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Stimulus
    initial begin
        int              pick;
        int              live;
        int              phase_len;
        int              roll;
        int              stop_at;
        kqfu_pkg::t_cnt  setting;
        kqfu_pkg::t_node a;
        kqfu_pkg::t_node b;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset size of 1024 nodes, extreme ids
        offer(ACT_EDGE, 10'd0, 10'd1023);
        offer(ACT_EDGE, 10'd1023, 10'd0);       // same component
        offer(ACT_EDGE, 10'd512, 10'd512);      // self loop
        offer(ACT_EDGE, 10'd700, 10'd300);
        offer(ACT_RESTART, 10'd1023, 10'd1023); // ids ignored
        // single node: done at once, never accepts
        write_node_count(11'd1);
        offer(ACT_EDGE, 10'd0, 10'd0);
        offer(ACT_EDGE, 10'd1, 10'd0);
        offer(ACT_EDGE, 10'd0, 10'd1023);
        // zero acts as one node
        write_node_count(11'd0);
        offer(ACT_EDGE, 10'd0, 10'd0);
        offer(ACT_EDGE, 10'd1023, 10'd1);
        // three nodes: merge to done, then edges after done and bad ids
        write_node_count(11'd3);
        offer(ACT_EDGE, 10'd2, 10'd1);
        offer(ACT_EDGE, 10'd1, 10'd0);
        offer(ACT_EDGE, 10'd2, 10'd0);
        offer(ACT_EDGE, 10'd3, 10'd0);
        offer(ACT_EDGE, 10'd0, 10'd3);
        offer(ACT_RESTART, 10'd0, 10'd0);
        offer(ACT_EDGE, 10'd0, 10'd2);
        // all-ones write is capped to the depth
        write_node_count(11'd2047);
        offer(ACT_EDGE, 10'd1023, 10'd1022);
        offer(ACT_EDGE, 10'd682, 10'd341);

        // Random phases, mostly small graphs so merges stay cheap
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 19);
            case (pick)
                0:       setting = 11'd0;
                1:       setting = 11'd1;
                2:       setting = 11'd1024;
                3:       setting = kqfu_pkg::t_cnt'($urandom_range(1025, 2047));
                default: setting = kqfu_pkg::t_cnt'($urandom_range(2, 24));
            endcase
            write_node_count(setting);
            live = (setting == 0) ? 1 : ((setting > 1024) ? 1024 : setting);
            phase_len = (live >= 1024) ? $urandom_range(8, 16)
                                       : $urandom_range(live + 2, 3 * live + 6);
            for (int k = 0; k < phase_len && items_sent < stop_at; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 5) begin
                    offer(ACT_RESTART, kqfu_pkg::t_node'($urandom_range(0, 1023)),
                          kqfu_pkg::t_node'($urandom_range(0, 1023)));
                end else if (roll < 13 && live < 1024) begin
                    // at least one endpoint out of range
                    a = kqfu_pkg::t_node'($urandom_range(0, 1023));
                    b = kqfu_pkg::t_node'($urandom_range(0, 1023));
                    if ($urandom_range(0, 1))
                        a = kqfu_pkg::t_node'($urandom_range(live, 1023));
                    else
                        b = kqfu_pkg::t_node'($urandom_range(live, 1023));
                    offer(ACT_EDGE, a, b);
                end else begin
                    offer(ACT_EDGE, kqfu_pkg::t_node'($urandom_range(0, live - 1)),
                          kqfu_pkg::t_node'($urandom_range(0, live - 1)));
                end
            end
        end

        // Drain: every result back, then one relabel sweep of quiet time
        if (start) start <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d transactions over %0d node-count settings, %0d restarts",
                 items_sent, settings, restarts);
        $display("%0d edges merged, %0d bad ids flagged, %0d results with the tree complete",
                 merges, bad_ids, done_results);
        if (fail_count == 0 && outstanding == 0) begin
            $display("kruskal_quick_find_union_unit_test: done, clean");
        end else begin
            $display("kruskal_quick_find_union_unit_test: done, errors");
        end
        $finish;
    end

    // Watchdog: cycles with no transaction, result or register write
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: %0d cycles without progress", idle_cycles);
            $display("kruskal_quick_find_union_unit_test: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== sim.f =====
hw/rtl/kqfu_pkg.sv
hw/rtl/kqfu_label_ram.sv
hw/rtl/kruskal_quick_find_union_unit.sv
tb/kqfu_merge_checker.sv
tb/kruskal_quick_find_union_unit_test.sv
